// ===== rtl/ihmb_pkg.sv =====
// ----------------------------------------------------------------------------
// ihmb_pkg
// Types and constants shared by the bucketed integer hash map.
// ----------------------------------------------------------------------------
package ihmb_pkg;

  localparam int unsigned BucketCount = 1024;
  localparam int unsigned BucketWays  = 8;
  localparam int unsigned BucketW     = $clog2(BucketCount);
  localparam int unsigned WayW        = $clog2(BucketWays);
  localparam int unsigned FillW       = $clog2(BucketWays + 1);
  localparam int unsigned KeyW        = 32;
  localparam int unsigned DataW       = 32;
  localparam int unsigned LineW       = BucketWays * (KeyW + DataW) + FillW;
  localparam int unsigned EpochW      = 8;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KeyW-1:0]  key;
    logic signed [DataW-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] data_out;
  } rsp_t;

  // One bucket line: entries in order plus the fill count
  typedef struct packed {
    logic [BucketWays-1:0][KeyW-1:0]  keys;
    logic [BucketWays-1:0][DataW-1:0] vals;
    logic [FillW-1:0]                 fill;
  } line_t;

  // Non-negative remainder; BucketCount is a power of two, so low bits do it
  function automatic logic [BucketW-1:0] bucket_of(input logic [KeyW-1:0] k);
    return k[BucketW-1:0];
  endfunction

endpackage

// ===== rtl/ihmb_line_update.sv =====
// ----------------------------------------------------------------------------
// ihmb_line_update
// Combines one bucket line with a request: way match, append, delete shift.
// ----------------------------------------------------------------------------
module ihmb_line_update (
  input  ihmb_pkg::line_t line_i,
  input  ihmb_pkg::req_t  req_i,
  input  logic            epoch_ok_i,
  output ihmb_pkg::line_t line_o,
  output logic            wr_o,
  output ihmb_pkg::rsp_t  rsp_o
);
  import ihmb_pkg::*;

  logic [FillW-1:0]      fill;
  logic [BucketWays-1:0] hit;
  logic [WayW-1:0]       way;
  logic                  found;

  // Stale epoch means the bucket was cleared since written
  always_comb begin
    fill = epoch_ok_i ? line_i.fill : '0;
    if (fill > FillW'(BucketWays)) fill = FillW'(BucketWays);
  end

  // Ways below the fill count are compared in parallel; first match wins
  always_comb begin
    hit   = '0;
    way   = '0;
    found = 1'b0;
    for (int i = 0; i < BucketWays; i++) begin
      hit[i] = (FillW'(i) < fill) && (line_i.keys[i] == req_i.key);
    end
    for (int i = BucketWays - 1; i >= 0; i--) begin
      if (hit[i]) begin
        way   = WayW'(i);
        found = 1'b1;
      end
    end
  end

  // Modify the line
  always_comb begin
    line_o          = line_i;
    line_o.fill     = fill;
    wr_o            = 1'b0;
    rsp_o.status    = ST_OK;
    rsp_o.data_out  = '0;
    case (req_i.req_type)
      REQ_SET: begin
        wr_o = 1'b1;
        if (found) begin
          line_o.vals[way] = req_i.data_in;
        end else if (fill < FillW'(BucketWays)) begin
          line_o.keys[fill[WayW-1:0]] = req_i.key;
          line_o.vals[fill[WayW-1:0]] = req_i.data_in;
          line_o.fill = fill + 1'b1;
        end else begin
          rsp_o.status = ST_FULL;
        end
      end
      REQ_LOOKUP: begin
        if (found) rsp_o.data_out = line_i.vals[way];
        else       rsp_o.status   = ST_NOT_FOUND;
      end
      REQ_DELETE: begin
        if (found) begin
          wr_o = 1'b1;
          // close the gap: each way from the hit up to the last but one takes its successor
          for (int i = 0; i < BucketWays - 1; i++) begin
            if (WayW'(i) >= way) begin
              line_o.keys[i] = line_i.keys[i+1];
              line_o.vals[i] = line_i.vals[i+1];
            end
          end
          line_o.fill = fill - 1'b1;
        end else begin
          rsp_o.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/int_hash_map_buckets_top.sv =====
// ----------------------------------------------------------------------------
// int_hash_map_buckets_top
// Bucketed integer key/value map, one line read-modify-write per request.
// ----------------------------------------------------------------------------
// The line is read into rd_q on accept and updated in S_RMW; the result
// strobe comes from rsp_valid_q, registered out of S_RMW. Busy stays high
// until the line is written back. Clear bumps an 8-bit epoch; the clear
// that wraps it adds a sweep of every line, with busy high throughout.
// Reset: the same sweep runs first; the receiver cannot stall.
module int_hash_map_buckets_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ihmb_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output ihmb_pkg::rsp_t rsp_o
);
  import ihmb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RMW  = 3'b010,
    S_CLR  = 3'b100
  } state_e;

  // Line memory with per-line epoch tag
  typedef struct packed {
    logic [EpochW-1:0] epoch;
    line_t             line;
  } entry_t;

  entry_t mem [BucketCount];
  entry_t rd_q;

  state_e state_q, state_d;
  req_t   req_q;
  logic [EpochW-1:0] epoch_q;
  logic   rsp_valid_q;
  rsp_t   rsp_q;
  // Sweep address: every line gets an empty fill after reset and epoch wrap
  logic [BucketW-1:0] clr_q;

  line_t line_new;
  logic  wr;
  rsp_t  rsp_new;
  logic  accept;
  logic [BucketW-1:0] bkt_q;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Synchronous memory: read into rd_q on accept, write back in S_RMW, sweep in S_CLR
  always_ff @(posedge clk_i) begin
    if (accept) rd_q <= mem[bucket_of(req_i.key)];
    if (state_q == S_CLR)
      mem[clr_q] <= '{epoch: epoch_q, line: '0};
    else if (state_q == S_RMW && wr && req_q.req_type != REQ_CLEAR)
      mem[bkt_q] <= '{epoch: epoch_q, line: line_new};
  end

  ihmb_line_update u_upd (
    .line_i     (rd_q.line),
    .req_i      (req_q),
    .epoch_ok_i (rd_q.epoch == epoch_q),
    .line_o     (line_new),
    .wr_o       (wr),
    .rsp_o      (rsp_new)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RMW;
      S_RMW: begin
        if (req_q.req_type == REQ_CLEAR && epoch_q == '1) state_d = S_CLR;
        else state_d = S_IDLE;
      end
      S_CLR:  if (clr_q == '1) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      epoch_q     <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= (state_q == S_RMW);
      if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
      if (state_q == S_RMW && req_q.req_type == REQ_CLEAR) begin
        epoch_q <= epoch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      bkt_q <= bucket_of(req_i.key);
    end
    if (state_q == S_RMW) begin
      rsp_q <= (req_q.req_type == REQ_CLEAR) ? rsp_t'{status: ST_OK, data_out: '0}
                                             : rsp_new;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // One result per accepted word, raised only after S_RMW
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 rsp_valid_o) else $error("missing result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q == S_RMW)) else $error("spurious result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("no interlock");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the bucketed integer hash map. A behavioral copy of
// the map works out each expected reply; every reply word is checked, field
// by field, against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import ihmb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  int_hash_map_buckets_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Behavioral map state
  logic [3:0]      map_fill [BucketCount];
  logic [KeyW-1:0] map_keys [BucketCount][BucketWays];
  logic [DataW-1:0] map_vals [BucketCount][BucketWays];

  rsp_t pending_rsp[$];
  int   n_fail = 0;
  int   n_words = 0;
  int   n_rsp = 0;
  int   n_full = 0;
  int   n_miss = 0;
  bit   allow_gaps = 1'b1;
  logic [KeyW-1:0] hot_keys[$];

  // Expected reply for one request, and the state update it causes
  function automatic rsp_t map_apply(req_t r);
    rsp_t o;
    int b, f, w;
    o = '0;
    if (r.req_type == REQ_CLEAR) begin
      foreach (map_fill[i]) map_fill[i] = '0;
      return o;
    end
    b = int'(r.key[BucketW-1:0]);
    f = map_fill[b];
    w = -1;
    for (int i = 0; i < f; i++)
      if (w < 0 && map_keys[b][i] == r.key) w = i;
    case (r.req_type)
      REQ_SET: begin
        if (w >= 0) map_vals[b][w] = r.data_in;
        else if (f < BucketWays) begin
          map_keys[b][f] = r.key;
          map_vals[b][f] = r.data_in;
          map_fill[b] = 4'(f + 1);
        end else o.status = ST_FULL;
      end
      REQ_LOOKUP: begin
        if (w >= 0) o.data_out = map_vals[b][w];
        else o.status = ST_NOT_FOUND;
      end
      default: begin
        if (w >= 0) begin
          for (int j = w; j + 1 < f; j++) begin
            map_keys[b][j] = map_keys[b][j+1];
            map_vals[b][j] = map_vals[b][j+1];
          end
          map_fill[b] = 4'(f - 1);
        end else o.status = ST_NOT_FOUND;
      end
    endcase
    return o;
  endfunction

  // Send one word, with an optional random gap before it
  task automatic send_word(input req_e op, input logic [KeyW-1:0] k,
                           input logic [DataW-1:0] d);
    req_t r;
    r.req_type = op;
    r.key = k;
    r.data_in = d;
    if (allow_gaps && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_rsp.push_back(map_apply(r));
    n_words++;
    @(negedge clk_i);
  endtask

  task automatic idle_line();
    start <= 1'b0;
    req_i <= '0;
  endtask

  // Reply checker
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid_o) begin
      n_rsp++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected reply status=%0d data=%0h", $time,
                 rsp_o.status, rsp_o.data_out);
        n_fail++;
      end else begin
        e = pending_rsp.pop_front();
        if (e.status == ST_FULL) n_full++;
        if (e.status == ST_NOT_FOUND) n_miss++;
        if (rsp_o.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_o.status);
          n_fail++;
        end
        if (rsp_o.data_out !== e.data_out) begin
          $display("%0t: data_out expected %0h actual %0h", $time,
                   e.data_out, rsp_o.data_out);
          n_fail++;
        end
      end
    end
  end

  // Field extremes, negative keys, every request type
  task automatic test_directed();
    send_word(REQ_LOOKUP, 32'h0, 32'h0);
    send_word(REQ_DELETE, 32'h0, 32'h0);
    send_word(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 32'h8000_0000, 32'h0);
    send_word(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_word(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_word(REQ_SET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_word(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_word(REQ_DELETE, 32'h7FFF_FFFF, 32'h0);
    send_word(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_word(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(REQ_LOOKUP, 32'h8000_0000, 32'h0);
  endtask

  // Fill one bucket past full, update, delete from the middle, refill
  task automatic test_bucket_full();
    for (int i = 0; i <= BucketWays; i++)
      send_word(REQ_SET, 32'(i * BucketCount + 5) ^ 32'h8000_0000, 32'(i + 100));
    send_word(REQ_SET, 32'h8000_0005, 32'hDEAD_BEEF);
    send_word(REQ_DELETE, 32'(3 * BucketCount + 5) ^ 32'h8000_0000, 32'h0);
    for (int i = 0; i <= BucketWays; i++)
      send_word(REQ_LOOKUP, 32'(i * BucketCount + 5) ^ 32'h8000_0000, 32'h0);
    send_word(REQ_SET, 32'h0000_0405, 32'h5);
  endtask

  // Random traffic over a few crowded buckets, plus some full-range noise
  task automatic test_random(input int n);
    logic [KeyW-1:0] k;
    int op;
    for (int i = 0; i < 16; i++)
      hot_keys.push_back({22'($urandom_range(31, 0) == 0 ? $urandom() >> 10 : $urandom()),
                          10'($urandom_range(5))});
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(9) < 8) ? hot_keys[$urandom_range(hot_keys.size() - 1)]
                                  : $urandom();
      op = $urandom_range(99);
      if (op < 45) send_word(REQ_SET, k, $urandom());
      else if (op < 75) send_word(REQ_LOOKUP, k, $urandom());
      else if (op < 98) send_word(REQ_DELETE, k, $urandom());
      else send_word(REQ_CLEAR, $urandom(), $urandom());
    end
  endtask

  initial begin
    foreach (map_fill[i]) map_fill[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_bucket_full();
    test_random(1250);
    allow_gaps = 1'b0;
    test_random(150);
    idle_line();
    for (int i = 0; i < 1000 && pending_rsp.size() != 0; i++) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    $display("Sent %0d words, got %0d replies (%0d bucket-full, %0d not-found).",
             n_words, n_rsp, n_full, n_miss);
    if (n_fail == 0 && pending_rsp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d replies missing", n_fail, pending_rsp.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("Timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
